[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is active.
`define BOE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define BOE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BOE_ASSERT(lbl, clk, rst_n, prop, msg)
`define BOE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/boe_pkg.sv]
// ----------------------------------------------------------------------------
// boe_pkg
// Shared constants, types and helpers of the OID arc encoder.
// ----------------------------------------------------------------------------
package boe_pkg;

    localparam int ARC_IN_W  = 64;                  // width of the arc field
    localparam int ARC_BITS  = 64;                  // arc bits kept (8..64)
    localparam int GROUPS    = (ARC_BITS + 6) / 7;  // base-128 groups per arc
    localparam int PAD_W     = GROUPS * 7;
    localparam int CNT_W     = $clog2(GROUPS);
    localparam int FIRST_MUL = 40;

    localparam logic [ARC_BITS-1:0] ARC_MASK = '1;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_LATER,
        POS_DISCARD
    } pos_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ERR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;     // capture the input item
        logic hold_first;  // keep the first arc
        logic load_arc;    // load the subidentifier and its group count
        logic combine;     // subidentifier is 40 * first + second
        logic load_err;    // put an error result in the output register
        logic load_byte;   // put the next group in the output register
    } dp_cmd_t;

    typedef struct packed {
        logic starts;      // captured item opens an identifier
        logic ends;        // captured item closes an identifier
        logic first_gt2;   // captured arc above two
        logic combo_ovf;   // 40 * first + arc does not fit
        logic last_group;  // group counter at the final group
        logic out_free;    // output register can take a result
    } dp_stat_t;

    // 40 times the held first arc
    function automatic logic [ARC_BITS-1:0] base_of(input logic [1:0] held);
        logic [ARC_BITS-1:0] b;
        case (held)
            2'd0:    b = '0;
            2'd1:    b = ARC_BITS'(FIRST_MUL);
            2'd2:    b = ARC_BITS'(2 * FIRST_MUL);
            default: b = ARC_BITS'(3 * FIRST_MUL);
        endcase
        return b;
    endfunction

    // 7-bit group idx of a value, group 0 the least significant
    function automatic logic [6:0] group_sel(input logic [ARC_BITS-1:0] v,
                                             input logic [CNT_W-1:0] idx);
        logic [PAD_W-1:0] ext;
        ext = PAD_W'(v);
        return ext[7*idx +: 7];
    endfunction

endpackage

[rtl/core/boe_ctrl.sv]
// ----------------------------------------------------------------------------
// boe_ctrl
// Sequencer: tracks the arc position and steps the datapath per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boe_ctrl
    import boe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     in_ready
);

    state_t state_reg, state_next;
    pos_t   pos_reg, pos_next;
    pos_t   pos_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= POS_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // a start flag always reopens the identifier
    assign pos_eff = stat.starts ? POS_FIRST : pos_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                case (pos_eff)
                    POS_FIRST:
                    begin
                        if (stat.first_gt2)
                        begin
                            pos_next   = stat.ends ? POS_FIRST : POS_DISCARD;
                            state_next = ST_ERR;
                        end
                        else if (stat.ends)
                        begin
                            pos_next   = POS_FIRST;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            pos_next   = POS_SECOND;
                            state_next = ST_IDLE;
                        end
                    end
                    POS_SECOND:
                    begin
                        if (stat.combo_ovf)
                        begin
                            pos_next   = stat.ends ? POS_FIRST : POS_DISCARD;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            pos_next   = stat.ends ? POS_FIRST : POS_LATER;
                            state_next = ST_EMIT;
                        end
                    end
                    POS_LATER:
                    begin
                        pos_next   = stat.ends ? POS_FIRST : POS_LATER;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        pos_next   = stat.ends ? POS_FIRST : POS_DISCARD;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ERR:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free && stat.last_group)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_EVAL:
            begin
                cmd.hold_first = (pos_eff == POS_FIRST) && !stat.first_gt2;
                cmd.load_arc   = ((pos_eff == POS_SECOND) && !stat.combo_ovf) ||
                                 (pos_eff == POS_LATER);
                cmd.combine    = (pos_eff == POS_SECOND);
            end
            ST_ERR:
            begin
                cmd.load_err = stat.out_free;
            end
            ST_EMIT:
            begin
                cmd.load_byte = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `BOE_ASSERT(a_accept_to_eval, clk, rst_n, (in_ready && s_tvalid) |=> (state_reg == ST_EVAL), "accepted item not evaluated")
    `BOE_ASSERT(a_emit_pos, clk, rst_n, (state_reg == ST_EMIT) |-> (pos_reg == POS_FIRST || pos_reg == POS_LATER), "emitting with bad arc position")
    `BOE_ASSERT(a_eval_one_cycle, clk, rst_n, (state_reg == ST_EVAL) |=> (state_reg != ST_EVAL), "evaluation took more than one cycle")

endmodule

[rtl/core/boe_datapath.sv]
// ----------------------------------------------------------------------------
// boe_datapath
// Arc capture, first-arc combination, base-128 group split, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module boe_datapath
    import boe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ARC_IN_W-1:0] arc_value,
    input  logic                starts_identifier,
    input  logic                ends_identifier,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          out_byte,
    output logic                last_of_arc,
    output logic                last_of_identifier,
    output logic                arc_error
);

    logic [ARC_BITS-1:0] arc_reg;
    logic                starts_reg;
    logic                ends_reg;
    logic [1:0]          held_reg;
    logic [ARC_BITS-1:0] sub_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [7:0]          byte_reg;
    logic                last_arc_reg;
    logic                last_id_reg;
    logic                err_reg;
    logic                out_valid_reg, out_valid_next;

    logic [ARC_BITS-1:0] base;
    logic [ARC_BITS-1:0] value_sel;
    logic [CNT_W-1:0]    top_grp;
    logic                out_free;
    logic                cnt_zero;

    assign base      = base_of(held_reg);
    assign value_sel = cmd.combine ? (arc_reg + base) : arc_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign cnt_zero  = (cnt_reg == '0);

    // index of the highest nonzero group; a zero value still takes one byte
    always_comb
    begin
        top_grp = '0;
        for (int g = 1; g < GROUPS; g++)
        begin
            if (|group_sel(value_sel, CNT_W'(g)))
                top_grp = CNT_W'(g);
        end
    end

    assign stat.starts     = starts_reg;
    assign stat.ends       = ends_reg;
    // above two: any upper bit set, or the low two bits both set
    assign stat.first_gt2  = (|arc_reg[ARC_BITS-1:2]) || (&arc_reg[1:0]);
    assign stat.combo_ovf  = arc_reg > (ARC_MASK - base);
    assign stat.last_group = cnt_zero;
    assign stat.out_free   = out_free;

    // item capture and group split, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            arc_reg    <= arc_value[ARC_BITS-1:0];
            starts_reg <= starts_identifier;
            ends_reg   <= ends_identifier;
        end
        if (cmd.load_arc)
        begin
            sub_reg <= value_sel;
            cnt_reg <= top_grp;
        end
        else if (cmd.load_byte && !cnt_zero)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.load_err)
        begin
            byte_reg     <= '0;
            last_arc_reg <= 1'b1;
            last_id_reg  <= ends_reg;
            err_reg      <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            byte_reg     <= {!cnt_zero, group_sel(sub_reg, cnt_reg)};
            last_arc_reg <= cnt_zero;
            last_id_reg  <= cnt_zero && ends_reg;
            err_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hold_first)
                held_reg <= arc_reg[1:0];
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (cmd.load_err || cmd.load_byte)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid           = out_valid_reg;
    assign out_byte           = byte_reg;
    assign last_of_arc        = last_arc_reg;
    assign last_of_identifier = last_id_reg;
    assign arc_error          = err_reg;

    `BOE_ASSERT(a_no_overwrite, clk, rst_n, (cmd.load_err || cmd.load_byte) |-> out_free, "output register overwritten while stalled")
    `BOE_ASSERT(a_cnt_range, clk, rst_n, cmd.load_byte |-> (cnt_reg < CNT_W'(GROUPS)), "group counter out of range")

endmodule

[rtl/core/ber_oid_arc_encoder.sv]
// ----------------------------------------------------------------------------
// ber_oid_arc_encoder
// BER object identifier arc encoder: arcs in, base-128 subidentifier bytes out.
// Flow: the accepted item is captured and evaluated, then its first byte (or
// error result) goes into the output register once that register is free.
// Output: one byte per cycle from the group counter while the output is free; a
// new item is taken only after the previous one is done (held, dropped or sent).
// Reset: asynchronous, active low; expects a first arc, held arc cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ber_oid_arc_encoder
    import boe_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input arcs
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ARC_IN_W-1:0] s_tdata,   // [63:0] arc_value
    input  logic                s_tuser,   // [0] starts_identifier
    input  logic                s_tlast,   // ends_identifier
    // encoded bytes
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic [1:0]          m_tuser,   // [0] last_of_arc, [1] arc_error
    output logic                m_tlast    // last_of_identifier
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     last_of_arc;
    logic     arc_error;

    // Sequencer: one item in flight. Idle -> evaluate position -> hold the
    // first arc, drop a discarded arc, emit one error result, or walk the groups
    // from the most significant one down, advancing only when the output is free.
    boe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_tready)
    );

    // Datapath: captures the item, forms 40 * first + second on the second
    // arc, finds the group count, and drives the output register.
    boe_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .arc_value          (s_tdata),
        .starts_identifier  (s_tuser),
        .ends_identifier    (s_tlast),
        .cmd                (cmd),
        .stat               (stat),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .out_byte           (m_tdata),
        .last_of_arc        (last_of_arc),
        .last_of_identifier (m_tlast),
        .arc_error          (arc_error)
    );

    assign m_tuser = {arc_error, last_of_arc};

    // an identifier end can only be flagged on the final byte of an arc
    `BOE_ASSERT(a_last_id_on_last_arc, clk, rst_n, (m_tvalid && m_tlast) |-> m_tuser[0], "identifier end without arc end")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ber_oid_arc_encoder. Object identifier arcs go in
// on the slave stream. A scoreboard predicts the subidentifier bytes and
// error items, and checks every item on the master stream in order. The run
// starts with a directed list of corner cases, then random identifiers and
// noise under four idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import boe_pkg::*;

    // one expected or observed output item
    typedef struct {
        logic [7:0] code;      // encoded byte
        logic       arc_end;   // last byte of the subidentifier
        logic       oid_end;   // last byte of the identifier
        logic       err;       // error item
    } enc_item_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks arc position and the held first arc, queues the
    // bytes each accepted arc must produce, and checks them in order.
    // ------------------------------------------------------------------------
    class oid_scoreboard;
        pos_t           position;
        logic [1:0]     held_first;
        enc_item_t      pending_q[$];
        int             mismatches;
        int             arcs_noted;
        int             bytes_checked;
        int             errors_seen;

        function new();
            position      = POS_FIRST;
            held_first    = '0;
            mismatches    = 0;
            arcs_noted    = 0;
            bytes_checked = 0;
            errors_seen   = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // append one expectation at the tail
        function void add_expected(enc_item_t e);
            pending_q = {pending_q, e};
        endfunction

        function void push_error(logic ends);
            enc_item_t e;
            e.code    = 8'h00;
            e.arc_end = 1'b1;
            e.oid_end = ends;
            e.err     = 1'b1;
            add_expected(e);
        endfunction

        // big-endian base-128 groups, continuation bit on all but the last
        function void push_groups(logic [ARC_BITS-1:0] v, logic ends);
            logic [63:0] w;
            enc_item_t   e;
            int          n;
            int          g;
            w = 64'(v);
            n = 1;
            while (n < 10 && (w >> (7 * n)) != 0)
                n++;
            for (int k = 0; k < n; k++)
            begin
                g         = n - 1 - k;
                e.code    = {(g != 0), 7'((w >> (7 * g)) & 64'h7F)};
                e.arc_end = (g == 0);
                e.oid_end = (g == 0) && ends;
                e.err     = 1'b0;
                add_expected(e);
            end
        endfunction

        // note one accepted arc and queue what it must produce
        function void note_arc(logic [63:0] raw, logic starts, logic ends);
            logic [ARC_BITS-1:0] v;
            logic [ARC_BITS-1:0] base;
            pos_t                where;
            v     = raw[ARC_BITS-1:0];
            where = starts ? POS_FIRST : position;
            arcs_noted++;
            case (where)
                POS_FIRST:
                begin
                    if (v > 2)
                    begin
                        push_error(ends);
                        position = ends ? POS_FIRST : POS_DISCARD;
                    end
                    else
                    begin
                        held_first = v[1:0];
                        if (ends)
                        begin
                            push_error(1'b1);
                            position = POS_FIRST;
                        end
                        else
                            position = POS_SECOND;
                    end
                end
                POS_SECOND:
                begin
                    base = ARC_BITS'(held_first) * ARC_BITS'(FIRST_MUL);
                    if (v > ARC_MASK - base)
                    begin
                        push_error(ends);
                        position = ends ? POS_FIRST : POS_DISCARD;
                    end
                    else
                    begin
                        push_groups(base + v, ends);
                        position = ends ? POS_FIRST : POS_LATER;
                    end
                end
                POS_LATER:
                begin
                    push_groups(v, ends);
                    position = ends ? POS_FIRST : POS_LATER;
                end
                default:
                    position = ends ? POS_FIRST : POS_DISCARD;
            endcase
        endfunction

        // compare one accepted output item with the oldest expectation
        function void check_item(logic [7:0] code, logic [1:0] user, logic last);
            enc_item_t want;
            bytes_checked++;
            if (user[1])
                errors_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected item: byte %02h arc_end %b err %b oid_end %b",
                             $realtime, code, user[0], user[1], last);
                return;
            end
            want = pending_q.pop_front();
            if (code !== want.code || user[0] !== want.arc_end ||
                user[1] !== want.err || last !== want.oid_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"[%0t] mismatch: exp byte %02h arc_end %b err %b oid_end %b,",
                              " got byte %02h arc_end %b err %b oid_end %b"},
                             $realtime, want.code, want.arc_end, want.err, want.oid_end,
                             code, user[0], user[1], last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [ARC_IN_W-1:0] s_tdata = '0;     // [63:0] arc_value
    logic                s_tuser = 1'b0;   // [0] starts_identifier
    logic                s_tlast = 1'b0;   // ends_identifier
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [7:0]          m_tdata;          // [7:0] out_byte
    logic [1:0]          m_tuser;          // [0] last_of_arc, [1] arc_error
    logic                m_tlast;          // last_of_identifier

    int send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    int arcs_sent      = 0;

    oid_scoreboard board = new();

    always #1 clk = ~clk;

    ber_oid_arc_encoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Receiver: stall at random, one decision per cycle.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Output monitor: values seen here are the ones present at the edge.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_item(m_tdata, m_tuser, m_tlast);

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("timeout: %0d items still expected", board.pending());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one arc, idling first at random; return after it is accepted.
    task automatic send_arc(input logic [63:0] v, input logic starts, input logic ends);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= starts;
        s_tlast  <= ends;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_arc(v, starts, ends);
        arcs_sent++;
    endtask

    // Drop valid and hold until every expected item has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Arc value with a random bit length, biased toward short arcs.
    function automatic logic [63:0] rand_arc();
        logic [63:0] raw;
        int          w;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:          return '1;
            1:          return '0;
            2, 3, 4, 5: w = $urandom_range(1, 14);
            default:    w = $urandom_range(15, 64);
        endcase
        return raw >> (64 - w);
    endfunction

    // Random part: mostly well-formed identifiers, the rest noise.
    task automatic run_random(input int budget);
        int          stop_at;
        int          nlater;
        logic [1:0]  first;
        logic [63:0] second;
        stop_at = arcs_sent + budget;
        while (arcs_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                nlater = $urandom_range(0, 4);
                first  = 2'($urandom_range(0, 2));
                // sometimes skip the start flag after a clean end
                send_arc(64'(first), ($urandom_range(9) != 0) ||
                         board.position != POS_FIRST, 1'b0);
                if ($urandom_range(99) < 15)
                    // straddle the combination overflow boundary
                    second = 64'(ARC_MASK) - 64'(first * FIRST_MUL) - 64'd1 +
                             64'($urandom_range(0, 2));
                else
                    second = rand_arc();
                send_arc(second, 1'b0, nlater == 0);
                for (int k = 0; k < nlater; k++)
                    send_arc(rand_arc(), 1'b0, k == nlater - 1);
            end
            else
            begin
                // noise: stray flags, first arcs above two, broken sequences
                send_arc(($urandom_range(1) != 0) ? 64'($urandom_range(0, 5)) : rand_arc(),
                         ($urandom_range(99) < 40), ($urandom_range(99) < 40));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corner cases, no idling.
        send_arc(64'd2, 1'b1, 1'b0);                    // hold first arc
        send_arc(64'd47, 1'b0, 1'b0);                   // combined 127, one byte
        send_arc(64'd128, 1'b0, 1'b0);                  // two bytes, zero low group
        send_arc('1, 1'b0, 1'b1);                       // all ones, ten bytes, end
        send_arc(64'd0, 1'b0, 1'b0);                    // no start flag: taken as first
        send_arc(64'd0, 1'b0, 1'b0);                    // combined zero
        send_arc(64'd1, 1'b1, 1'b0);                    // start flag abandons identifier
        send_arc(64'(ARC_MASK) - 64'd40, 1'b0, 1'b1);   // largest combination that fits
        send_arc(64'd2, 1'b1, 1'b0);
        send_arc(64'(ARC_MASK) - 64'd79, 1'b0, 1'b0);   // combination overflow
        send_arc(64'd5, 1'b0, 1'b0);                    // discarded
        send_arc(64'd7, 1'b0, 1'b1);                    // discarded, end returns to first
        send_arc(64'd3, 1'b1, 1'b0);                    // first arc above two
        send_arc(64'd1, 1'b1, 1'b0);                    // start flag ends discarding
        send_arc(64'd0, 1'b0, 1'b0);                    // combined 40
        send_arc(64'd0, 1'b0, 1'b1);                    // later arc zero, end
        send_arc(64'd2, 1'b1, 1'b1);                    // identifier of one arc
        send_arc(64'd9, 1'b1, 1'b1);                    // first above two with end
        send_arc('1, 1'b1, 1'b0);                       // all ones as first arc, above two
        send_arc(64'd0, 1'b0, 1'b1);                    // discard then end
        send_arc(64'd0, 1'b1, 1'b0);
        send_arc('1, 1'b0, 1'b0);                       // combined all ones
        send_arc(64'h8000_0000_0000_0000, 1'b0, 1'b1);  // top bit alone
        send_arc(64'd1, 1'b1, 1'b0);
        send_arc(64'(ARC_MASK) - 64'd39, 1'b0, 1'b1);   // overflow carrying end
        drain();

        // Random phases; hold the sender after each until the output is empty.
        run_random(45);
        drain();

        send_idle_pct  = 49;
        run_random(40);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 49;
        run_random(40);
        drain();

        send_idle_pct  = 32;
        recv_stall_pct = 32;
        run_random(40);
        drain();

        // let any arc still inside the block finish
        repeat (24) @(posedge clk);

        $display("covered %0d arcs in, %0d items out (%0d error items)",
                 arcs_sent, board.bytes_checked, board.errors_seen);
        $display("phases: no idling, sender idle, receiver stall, both; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/boe_pkg.sv
rtl/core/boe_ctrl.sv
rtl/core/boe_datapath.sv
rtl/core/ber_oid_arc_encoder.sv
test/testbench.sv
